// ----- hw/rtl/aos_pkg.sv -----
// Shared types, codes and helper functions for the operand address sequencer.
// Depends on nothing; every other file of the block but aos_if imports it.
package aos_pkg;

   // item kind on the request channel
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   // item kind on the response channel
   localparam logic RESULT_READ = 1'b0;
   localparam logic RESULT_DONE = 1'b1;

   typedef enum logic [3:0] {
      MODE_IMM  = 4'd0,
      MODE_ZP   = 4'd1,
      MODE_ZPX  = 4'd2,
      MODE_ZPY  = 4'd3,
      MODE_ABS  = 4'd4,
      MODE_ABSX = 4'd5,
      MODE_ABSY = 4'd6,
      MODE_INDX = 4'd7,
      MODE_INDY = 4'd8,
      MODE_IND  = 4'd9
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_OP_LO  = 3'd1,
      PH_OP_HI  = 3'd2,
      PH_PTR_LO = 3'd3,
      PH_PTR_HI = 3'd4,
      PH_VALUE  = 3'd5
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  mode;
      logic [15:0] program_counter;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic        fetch_value;
      logic [7:0]  read_data;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] read_address;
      logic [15:0] effective_address;
      logic [7:0]  operand_value;
      logic [15:0] next_program_counter;
   } rsp_item_type;

   // status of the item sitting in the input register
   typedef struct packed {
      logic item_valid;
      logic has_result;
   } step_status_type;

   // map a raw mode code; unused codes behave as immediate
   function automatic mode_type decode_mode(input logic [3:0] code);
      mode_type m;
      unique case (code)
         4'd1:    m = MODE_ZP;
         4'd2:    m = MODE_ZPX;
         4'd3:    m = MODE_ZPY;
         4'd4:    m = MODE_ABS;
         4'd5:    m = MODE_ABSX;
         4'd6:    m = MODE_ABSY;
         4'd7:    m = MODE_INDX;
         4'd8:    m = MODE_INDY;
         4'd9:    m = MODE_IND;
         default: m = MODE_IMM;
      endcase
      return m;
   endfunction

   // modes whose operand takes two bytes after the opcode
   function automatic logic is_two_byte(input mode_type m);
      return (m == MODE_ABS) || (m == MODE_ABSX) || (m == MODE_ABSY) || (m == MODE_IND);
   endfunction

endpackage

// ----- hw/rtl/aos_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; used by the top level and its stages.
interface aos_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  mode;
   logic [15:0] program_counter;
   logic [7:0]  index_x;
   logic [7:0]  index_y;
   logic        fetch_value;
   logic [7:0]  read_data;

   modport source (output valid, kind, mode, program_counter, index_x, index_y,
                   fetch_value, read_data, input ready);
   modport sink   (input valid, kind, mode, program_counter, index_x, index_y,
                   fetch_value, read_data, output ready);
endinterface

interface aos_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] read_address;
   logic [15:0] effective_address;
   logic [7:0]  operand_value;
   logic [15:0] next_program_counter;

   modport source (output valid, result_kind, read_address, effective_address,
                   operand_value, next_program_counter, input ready);
   modport sink   (input valid, result_kind, read_address, effective_address,
                   operand_value, next_program_counter, output ready);
endinterface

// ----- hw/rtl/aos_in_stage.sv -----
// Input register of the sequencer: captures one request item per cycle while it is empty or its item moves on.
// Depends on aos_pkg and aos_req_if.
module aos_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   aos_req_if.sink              req_chan,
   input  logic                 advance,
   output aos_pkg::req_item_type item,
   output logic                 item_valid
);
   import aos_pkg::*;

   req_item_type in_ff, in_in;
   logic         valid_ff, valid_in;
   logic         take;

   // accept while empty or while the held item moves on
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_in = in_ff;
      if (take) begin
         in_in.kind            = req_chan.kind;
         in_in.mode            = req_chan.mode;
         in_in.program_counter = req_chan.program_counter;
         in_in.index_x         = req_chan.index_x;
         in_in.index_y         = req_chan.index_y;
         in_in.fetch_value     = req_chan.fetch_value;
         in_in.read_data       = req_chan.read_data;
      end
   end

   // hold, refill or drain the valid flag
   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   assign item       = in_ff;
   assign item_valid = valid_ff;

endmodule

// ----- hw/rtl/aos_step_unit.sv -----
// Sequencer state and the per-item step logic between the two registers.
// Depends on aos_pkg.
module aos_step_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  aos_pkg::req_item_type    item,
   input  logic                     item_valid,
   input  logic                     commit,
   output aos_pkg::rsp_item_type    result,
   output aos_pkg::step_status_type status
);
   import aos_pkg::*;

   phase_type   phase_ff, phase_in;
   mode_type    mode_ff, mode_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic        want_ff, want_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] work_ff, work_in;

   logic        start;
   mode_type    cur_mode;
   logic [15:0] cur_pc;
   logic [7:0]  cur_x;
   logic [7:0]  cur_y;
   logic        cur_want;
   logic [15:0] cur_npc;
   logic [7:0]  d;
   logic [7:0]  zp_x_sum;
   logic [7:0]  zp_y_sum;
   logic [7:0]  ptr_step;
   logic [15:0] word_addr;

   logic        fin;
   logic [15:0] fin_ea;
   logic        go_req;
   logic [15:0] req_addr;
   phase_type   req_phase;
   logic        val_done;
   logic        has_result;
   logic        is_done;

   // operands seen by the step: fresh fields on a start, saved ones otherwise
   assign start    = (item.kind == KIND_START);
   assign d        = item.read_data;
   assign cur_mode = start ? decode_mode(item.mode) : mode_ff;
   assign cur_pc   = start ? item.program_counter : pc_ff;
   assign cur_x    = start ? item.index_x : x_ff;
   assign cur_y    = start ? item.index_y : y_ff;
   assign cur_want = start ? item.fetch_value : want_ff;
   assign cur_npc  = cur_pc + (is_two_byte(cur_mode) ? 16'd2 : 16'd1);

   assign zp_x_sum  = d + x_ff;
   assign zp_y_sum  = d + y_ff;
   assign ptr_step  = work_ff[7:0] + 8'd1;
   assign word_addr = {d, low_ff};

   // address datapath: decide between a finish, a further read or the value
   always_comb begin
      fin       = 1'b0;
      fin_ea    = '0;
      go_req    = 1'b0;
      req_addr  = '0;
      req_phase = phase_ff;
      val_done  = 1'b0;
      low_in    = low_ff;
      work_in   = work_ff;
      if (item_valid) begin
         if (start) begin
            low_in  = '0;
            work_in = '0;
            if (cur_mode == MODE_IMM) begin
               fin    = 1'b1;
               fin_ea = cur_pc;
            end else begin
               go_req    = 1'b1;
               req_addr  = cur_pc;
               req_phase = PH_OP_LO;
            end
         end else begin
            unique case (phase_ff)
               PH_OP_LO: begin
                  low_in = d;
                  unique case (mode_ff)
                     MODE_ZP: begin
                        fin    = 1'b1;
                        fin_ea = {8'h00, d};
                     end
                     MODE_ZPX: begin
                        fin    = 1'b1;
                        fin_ea = {8'h00, zp_x_sum};
                     end
                     MODE_ZPY: begin
                        fin    = 1'b1;
                        fin_ea = {8'h00, zp_y_sum};
                     end
                     MODE_INDX: begin
                        work_in   = {8'h00, zp_x_sum};
                        go_req    = 1'b1;
                        req_addr  = {8'h00, zp_x_sum};
                        req_phase = PH_PTR_LO;
                     end
                     MODE_INDY: begin
                        work_in   = {8'h00, d};
                        go_req    = 1'b1;
                        req_addr  = {8'h00, d};
                        req_phase = PH_PTR_LO;
                     end
                     default: begin
                        go_req    = 1'b1;
                        req_addr  = pc_ff + 16'd1;
                        req_phase = PH_OP_HI;
                     end
                  endcase
               end
               PH_OP_HI: begin
                  unique case (mode_ff)
                     MODE_ABSX: begin
                        fin    = 1'b1;
                        fin_ea = word_addr + {8'h00, x_ff};
                     end
                     MODE_ABSY: begin
                        fin    = 1'b1;
                        fin_ea = word_addr + {8'h00, y_ff};
                     end
                     MODE_IND: begin
                        work_in   = word_addr;
                        go_req    = 1'b1;
                        req_addr  = word_addr;
                        req_phase = PH_PTR_LO;
                     end
                     default: begin
                        fin    = 1'b1;
                        fin_ea = word_addr;
                     end
                  endcase
               end
               PH_PTR_LO: begin
                  // jump indirect steps the pointer across pages, the others wrap
                  low_in    = d;
                  go_req    = 1'b1;
                  req_phase = PH_PTR_HI;
                  req_addr  = (mode_ff == MODE_IND) ? work_ff + 16'd1 : {8'h00, ptr_step};
               end
               PH_PTR_HI: begin
                  fin    = 1'b1;
                  fin_ea = (mode_ff == MODE_INDY) ? word_addr + {8'h00, y_ff} : word_addr;
               end
               PH_VALUE: begin
                  val_done = 1'b1;
               end
               default: begin
                  // data while idle: drop it
               end
            endcase
         end
         if (fin && cur_want) begin
            work_in = fin_ea;
         end
      end
   end

   // next phase
   always_comb begin
      priority if (!item_valid) begin
         phase_in = phase_ff;
      end else if (fin) begin
         phase_in = cur_want ? PH_VALUE : PH_IDLE;
      end else if (val_done) begin
         phase_in = PH_IDLE;
      end else begin
         phase_in = req_phase;
      end
   end

   // result fields
   always_comb begin
      has_result = fin || go_req || val_done;
      is_done    = (fin && !cur_want) || val_done;
      result.result_kind = is_done ? RESULT_DONE : RESULT_READ;
      priority if (go_req) begin
         result.read_address = req_addr;
      end else if (fin && cur_want) begin
         result.read_address = fin_ea;
      end else begin
         result.read_address = '0;
      end
      priority if (fin && !cur_want) begin
         result.effective_address = fin_ea;
      end else if (val_done) begin
         result.effective_address = work_ff;
      end else begin
         result.effective_address = '0;
      end
      result.operand_value        = val_done ? d : 8'h00;
      result.next_program_counter = is_done ? cur_npc : 16'h0000;
      status.item_valid = item_valid;
      status.has_result = has_result;
   end

   // latch the start fields
   always_comb begin
      mode_in = mode_ff;
      pc_in   = pc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      want_in = want_ff;
      if (item_valid && start) begin
         mode_in = cur_mode;
         pc_in   = cur_pc;
         x_in    = cur_x;
         y_in    = cur_y;
         want_in = cur_want;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (commit) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         mode_ff <= mode_in;
         pc_ff   <= pc_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         want_ff <= want_in;
         low_ff  <= low_in;
         work_ff <= work_in;
      end
   end

   // a committed completion leaves the sequencer idle
   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      commit && has_result && is_done |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after a completion");

   // a committed start of a memory mode waits for the first operand byte
   a_start_op_lo: assert property (@(posedge clock) disable iff (reset)
      commit && start && (cur_mode != MODE_IMM) |=> phase_ff == PH_OP_LO)
      else $error("start did not enter the operand phase");

   // returned data while idle yields nothing
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      item_valid && !start && (phase_ff == PH_IDLE) |-> !has_result)
      else $error("result produced from idle data");

   // the value phase is only reached when fetching
   a_value_wanted: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> want_ff)
      else $error("value phase without fetch request");

endmodule

// ----- hw/rtl/aos_out_stage.sv -----
// Result register of the sequencer: holds one response item until taken.
// Depends on aos_pkg and aos_rsp_if.
module aos_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  aos_pkg::rsp_item_type result,
   input  logic                  load,
   output logic                  slot_free,
   aos_rsp_if.source             rsp_chan
);
   import aos_pkg::*;

   rsp_item_type rsp_ff, rsp_in;
   logic         valid_ff, valid_in;

   // the slot frees up in the cycle its item is taken
   assign slot_free = !valid_ff || rsp_chan.ready;

   assign rsp_in = load ? result : rsp_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid                = valid_ff;
   assign rsp_chan.result_kind          = rsp_ff.result_kind;
   assign rsp_chan.read_address         = rsp_ff.read_address;
   assign rsp_chan.effective_address    = rsp_ff.effective_address;
   assign rsp_chan.operand_value        = rsp_ff.operand_value;
   assign rsp_chan.next_program_counter = rsp_ff.next_program_counter;

endmodule

// ----- hw/rtl/cpu_operand_address_sequencer_core.sv -----
// Operand address sequencer for 6502-style addressing modes.
// Requests arrive on req_chan, responses leave on rsp_chan.
//
// A start item (kind 0) carries mode, program counter, X, Y and the fetch
// flag. Each response either asks for a bus read at read_address or reports
// completion with the effective address, the operand value and the advanced
// program counter. The user answers every read with a data item (kind 1)
// carrying the byte read. A start item abandons any sequence in progress;
// data arriving while idle is dropped without a response.
//
// Data path: an accepted item is registered in the input register; its
// response, if any, is registered in the result register once that slot is
// free, and rsp_chan offers it from there. Throughput is one item per cycle
// while the receiver does not stall; the step logic between the registers is
// combinational. A complete sequence takes one item per bus read plus the
// start item.
// Reset (synchronous, active high) empties both registers and returns the
// sequencer to idle. When the receiver stalls, the result register holds
// its item; ready drops once the input register holds an item with a result.
module cpu_operand_address_sequencer_core (
   input  logic      clock,
   input  logic      reset,
   aos_req_if.sink   req_chan,
   aos_rsp_if.source rsp_chan
);
   import aos_pkg::*;

   req_item_type    item;
   logic            item_valid;
   rsp_item_type    result;
   step_status_type status;
   logic            slot_free;
   logic            advance;
   logic            load;

   // move the held item on when its result, if any, has somewhere to go
   assign advance = status.item_valid && (!status.has_result || slot_free);
   assign load    = advance && status.has_result;

   aos_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item       (item),
      .item_valid (item_valid)
   );

   aos_step_unit u_step_unit (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .commit     (advance),
      .result     (result),
      .status     (status)
   );

   aos_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .load      (load),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the operand address sequencer: directed rows, then random
// addressing sequences under three idling mixes, checked against an in-bench predictor.
// Depends on aos_pkg, the aos_req_if/aos_rsp_if interfaces and cpu_operand_address_sequencer_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import aos_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 330;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;

   aos_req_if req_bus ();
   aos_rsp_if rsp_bus ();

   // predictor copy of the sequencer state
   phase_type   seq_phase;
   mode_type    seq_mode;
   logic [15:0] seq_pc;
   logic [7:0]  seq_x;
   logic [7:0]  seq_y;
   logic        seq_fetch;
   logic [7:0]  seq_low;
   logic [15:0] seq_work;

   rsp_item_type  address_results_due [$];
   table_row_type directed_rows [$];
   rsp_item_type  seen_rsp;
   rsp_item_type  owed_rsp;

   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_len;
   int hold_req;
   int mismatches;
   int accepted_items;
   int answered_items;
   int restarts;
   int strays;
   int results_checked;
   int cycle_count;

   cpu_operand_address_sequencer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   // abandon the run if it stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // result builders
   function automatic rsp_item_type read_rsp(input logic [15:0] addr);
      rsp_item_type r;
      r = '0;
      r.result_kind = RESULT_READ;
      r.read_address = addr;
      return r;
   endfunction

   function automatic rsp_item_type done_rsp(input logic [15:0] ea, input logic [7:0] val,
                                             input logic [15:0] npc);
      rsp_item_type r;
      r = '0;
      r.result_kind = RESULT_DONE;
      r.effective_address = ea;
      r.operand_value = val;
      r.next_program_counter = npc;
      return r;
   endfunction

   // close the sequence with the program counter stepped past the operand bytes
   function automatic rsp_item_type sequence_done(input logic [15:0] ea, input logic [7:0] val);
      logic [15:0] npc;
      case (seq_mode)
         MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: npc = seq_pc + 16'd2;
         default: npc = seq_pc + 16'd1;
      endcase
      seq_phase = PH_IDLE;
      return done_rsp(ea, val, npc);
   endfunction

   // address known: either fetch the operand or report completion
   function automatic rsp_item_type conclude(input logic [15:0] ea);
      if (seq_fetch) begin
         seq_work = ea;
         seq_phase = PH_VALUE;
         return read_rsp(ea);
      end
      return sequence_done(ea, 8'h00);
   endfunction

   // advance the predictor by one item; returns 1 when the item yields a result
   function automatic bit sequence_operand(input req_item_type it, output rsp_item_type res);
      logic [15:0] addr;
      logic [7:0]  d;
      d = it.read_data;
      res = '0;
      if (it.kind == KIND_START) begin
         seq_mode = (it.mode > MODE_IND) ? MODE_IMM : mode_type'(it.mode);
         seq_pc = it.program_counter;
         seq_x = it.index_x;
         seq_y = it.index_y;
         seq_fetch = it.fetch_value;
         seq_low = 8'h00;
         seq_work = 16'h0000;
         if (seq_mode == MODE_IMM) begin
            res = conclude(seq_pc);
            return 1'b1;
         end
         seq_phase = PH_OP_LO;
         res = read_rsp(seq_pc);
         return 1'b1;
      end
      case (seq_phase)
         PH_OP_LO: begin
            seq_low = d;
            case (seq_mode)
               MODE_ZP:  res = conclude({8'h00, d});
               MODE_ZPX: res = conclude({8'h00, 8'(d + seq_x)});
               MODE_ZPY: res = conclude({8'h00, 8'(d + seq_y)});
               MODE_INDX: begin
                  seq_work = {8'h00, 8'(d + seq_x)};
                  seq_phase = PH_PTR_LO;
                  res = read_rsp(seq_work);
               end
               MODE_INDY: begin
                  seq_work = {8'h00, d};
                  seq_phase = PH_PTR_LO;
                  res = read_rsp(seq_work);
               end
               default: begin
                  seq_phase = PH_OP_HI;
                  res = read_rsp(seq_pc + 16'd1);
               end
            endcase
         end
         PH_OP_HI: begin
            addr = {d, seq_low};
            if (seq_mode == MODE_ABSX) res = conclude(addr + {8'h00, seq_x});
            else if (seq_mode == MODE_ABSY) res = conclude(addr + {8'h00, seq_y});
            else if (seq_mode == MODE_IND) begin
               seq_work = addr;
               seq_phase = PH_PTR_LO;
               res = read_rsp(addr);
            end else res = conclude(addr);
         end
         PH_PTR_LO: begin
            seq_low = d;
            seq_phase = PH_PTR_HI;
            // jump indirect crosses the page; zero-page pointers wrap
            if (seq_mode == MODE_IND) res = read_rsp(seq_work + 16'd1);
            else res = read_rsp({8'h00, 8'(seq_work[7:0] + 8'd1)});
         end
         PH_PTR_HI: begin
            addr = {d, seq_low};
            if (seq_mode == MODE_INDY) addr = addr + {8'h00, seq_y};
            res = conclude(addr);
         end
         PH_VALUE: res = sequence_done(seq_work, d);
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // stimulus builders
   function automatic req_item_type start_item(input logic [3:0] m, input logic [15:0] pc,
                                                input logic [7:0] x, input logic [7:0] y,
                                                input logic f);
      req_item_type r;
      r = '0;
      r.kind = KIND_START;
      r.mode = m;
      r.program_counter = pc;
      r.index_x = x;
      r.index_y = y;
      r.fetch_value = f;
      return r;
   endfunction

   function automatic req_item_type data_item(input logic [7:0] d);
      req_item_type r;
      r = '0;
      r.kind = KIND_DATA;
      r.read_data = d;
      return r;
   endfunction

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] corner_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'hFF, corner_byte()};
         3: return {corner_byte(), 8'hFF};
         default: return 16'($urandom);
      endcase
   endfunction

   // every field random so unused fields toggle as well
   function automatic req_item_type random_item(input logic kind);
      req_item_type r;
      r.kind = kind;
      r.mode = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9, 0));
      r.program_counter = corner_word();
      r.index_x = corner_byte();
      r.index_y = corner_byte();
      r.fetch_value = 1'($urandom);
      r.read_data = corner_byte();
      return r;
   endfunction

   function automatic void add_row(input req_item_type it, input bit typed,
                                   input rsp_item_type want);
      table_row_type row;
      row.item = it;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // offer one item, hold it until accepted, then predict
   task automatic deliver(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type predicted;
      bit answered;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= it.kind;
      req_bus.mode <= it.mode;
      req_bus.program_counter <= it.program_counter;
      req_bus.index_x <= it.index_x;
      req_bus.index_y <= it.index_y;
      req_bus.fetch_value <= it.fetch_value;
      req_bus.read_data <= it.read_data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      accepted_items++;
      if (it.kind == KIND_START) begin
         if (seq_phase != PH_IDLE) restarts++;
      end else if (seq_phase == PH_IDLE) begin
         strays++;
      end
      answered = sequence_operand(it, predicted);
      if (answered) begin
         answered_items++;
         address_results_due.push_back(typed ? want : predicted);
      end
   endtask

   // hold the sender until every predicted result has come back
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (address_results_due.size() != 0) @(posedge clock);
   endtask

   // one addressing sequence: mostly well formed, sometimes cut short or stray data
   task automatic random_sequence();
      if ($urandom_range(99) < 4) begin
         deliver(random_item(KIND_DATA), 1'b0, '0);
         return;
      end
      deliver(random_item(KIND_START), 1'b0, '0);
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(99) < 3) break;
         deliver(random_item(KIND_DATA), 1'b0, '0);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int target;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      target = answered_items + ITEMS_PER_PHASE;
      while (answered_items < target) random_sequence();
      drain();
   endtask

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      int hold_ack;
      int hold_left;
      hold_ack = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen_rsp.result_kind = rsp_bus.result_kind;
         seen_rsp.read_address = rsp_bus.read_address;
         seen_rsp.effective_address = rsp_bus.effective_address;
         seen_rsp.operand_value = rsp_bus.operand_value;
         seen_rsp.next_program_counter = rsp_bus.next_program_counter;
         results_checked++;
         if (address_results_due.size() == 0) begin
            report_mismatch("unexpected result, read_address", seen_rsp.read_address, 0);
         end else begin
            owed_rsp = address_results_due.pop_front();
            if (seen_rsp.result_kind !== owed_rsp.result_kind)
               report_mismatch("result_kind", seen_rsp.result_kind, owed_rsp.result_kind);
            if (seen_rsp.read_address !== owed_rsp.read_address)
               report_mismatch("read_address", seen_rsp.read_address, owed_rsp.read_address);
            if (seen_rsp.effective_address !== owed_rsp.effective_address)
               report_mismatch("effective_address", seen_rsp.effective_address,
                               owed_rsp.effective_address);
            if (seen_rsp.operand_value !== owed_rsp.operand_value)
               report_mismatch("operand_value", seen_rsp.operand_value, owed_rsp.operand_value);
            if (seen_rsp.next_program_counter !== owed_rsp.next_program_counter)
               report_mismatch("next_program_counter", seen_rsp.next_program_counter,
                               owed_rsp.next_program_counter);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_START;
      req_bus.mode = MODE_IMM;
      req_bus.program_counter = '0;
      req_bus.index_x = '0;
      req_bus.index_y = '0;
      req_bus.fetch_value = 1'b0;
      req_bus.read_data = '0;
      seq_phase = PH_IDLE;
      seq_mode = MODE_IMM;
      seq_pc = '0;
      seq_x = '0;
      seq_y = '0;
      seq_fetch = 1'b0;
      seq_low = '0;
      seq_work = '0;
      sender_idle_pct = 6;
      receiver_idle_pct = 65;
      hold_len = 0;
      hold_req = 0;

      // directed rows: stray data, immediate, undefined mode, each mode, wraps, restart
      add_row(data_item(8'hFF), 1'b0, '0);
      add_row(start_item(MODE_IMM, 16'hFFFF, 8'h00, 8'h00, 1'b0), 1'b1,
              done_rsp(16'hFFFF, 8'h00, 16'h0000));
      add_row(start_item(MODE_IMM, 16'h1234, 8'hFF, 8'hFF, 1'b1), 1'b1, read_rsp(16'h1234));
      add_row(data_item(8'hAB), 1'b1, done_rsp(16'h1234, 8'hAB, 16'h1235));
      add_row(start_item(4'hF, 16'h8000, 8'h00, 8'h00, 1'b0), 1'b1,
              done_rsp(16'h8000, 8'h00, 16'h8001));
      add_row(start_item(MODE_ZP, 16'h0010, 8'h00, 8'h00, 1'b0), 1'b1, read_rsp(16'h0010));
      add_row(data_item(8'hFF), 1'b1, done_rsp(16'h00FF, 8'h00, 16'h0011));
      add_row(start_item(MODE_ZPX, 16'h00FF, 8'hFF, 8'h00, 1'b0), 1'b1, read_rsp(16'h00FF));
      add_row(data_item(8'h80), 1'b1, done_rsp(16'h007F, 8'h00, 16'h0100));
      add_row(start_item(MODE_ZPY, 16'h0200, 8'h00, 8'h01, 1'b0), 1'b1, read_rsp(16'h0200));
      add_row(data_item(8'hFF), 1'b1, done_rsp(16'h0000, 8'h00, 16'h0201));
      add_row(start_item(MODE_ABS, 16'h0FFF, 8'h00, 8'h00, 1'b0), 1'b1, read_rsp(16'h0FFF));
      add_row(data_item(8'h34), 1'b1, read_rsp(16'h1000));
      add_row(data_item(8'h12), 1'b1, done_rsp(16'h1234, 8'h00, 16'h1001));
      add_row(start_item(MODE_ABSX, 16'hFFFF, 8'hFF, 8'h00, 1'b0), 1'b1, read_rsp(16'hFFFF));
      add_row(data_item(8'hFF), 1'b1, read_rsp(16'h0000));
      add_row(data_item(8'hFF), 1'b1, done_rsp(16'h00FE, 8'h00, 16'h0001));
      add_row(start_item(MODE_ABSY, 16'h4000, 8'h00, 8'h02, 1'b1), 1'b0, '0);
      add_row(data_item(8'hFF), 1'b0, '0);
      add_row(data_item(8'hFF), 1'b0, '0);
      add_row(start_item(MODE_INDX, 16'h0400, 8'h05, 8'h00, 1'b0), 1'b1, read_rsp(16'h0400));
      add_row(data_item(8'hFE), 1'b1, read_rsp(16'h0003));
      add_row(start_item(MODE_IND, 16'h0300, 8'h00, 8'h00, 1'b0), 1'b1, read_rsp(16'h0300));
      add_row(data_item(8'hFF), 1'b1, read_rsp(16'h0301));
      add_row(data_item(8'h12), 1'b1, read_rsp(16'h12FF));
      add_row(data_item(8'h34), 1'b1, read_rsp(16'h1300));
      add_row(data_item(8'h56), 1'b1, done_rsp(16'h5634, 8'h00, 16'h0302));
      add_row(start_item(MODE_INDY, 16'h0050, 8'h00, 8'h80, 1'b0), 1'b0, '0);
      add_row(data_item(8'hFF), 1'b0, '0);
      add_row(data_item(8'h80), 1'b0, '0);
      add_row(data_item(8'hFF), 1'b0, '0);

      // hold reset, then release on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         deliver(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      drain();

      // random part: sender rarely idle, then receiver rarely idle, then neither after a long hold-off
      run_phase(6, 65);
      run_phase(65, 6);
      hold_len = HOLD_OFF_CYCLES;
      hold_req++;
      run_phase(0, 0);

      // let any stray result surface before the verdict
      repeat (10) @(posedge clock);
      if (address_results_due.size() != 0)
         report_mismatch("results never delivered", address_results_due.size(), 0);

      $display("covered %0d items (%0d answered, %0d restarts, %0d stray data items)",
               accepted_items, answered_items, restarts, strays);
      $display("checked %0d results over all modes, undefined codes and a %0d-cycle hold-off",
               results_checked, HOLD_OFF_CYCLES);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
